// ----- rtl/scm_pkg.sv -----
// Shared types and constants for the sample covariance matrix block.
// No dependencies; every other file in rtl imports this package.
package scm_pkg;

   localparam int SUM_BITS        = 48;
   localparam int COV_BITS        = 34;
   localparam int BAND_IDX_BITS   = 3;
   localparam int RSP_DATA_BITS   = 2 * BAND_IDX_BITS + COV_BITS;
   localparam int BAND_CNT_BITS   = 4;
   localparam int SAMPLE_CNT_BITS = 13;
   localparam int CSR_ADDR_BITS   = 3;
   localparam int CSR_DATA_BITS   = 32;
   localparam int CSR_IDX_BIT     = 2;
   localparam int QUEUE_DEPTH     = 4;

   localparam logic [BAND_CNT_BITS-1:0]   BAND_COUNT_RESET   = 4'd3;
   localparam logic [SAMPLE_CNT_BITS-1:0] SAMPLE_COUNT_RESET = 13'd4096;

   localparam logic CSR_BAND_COUNT   = 1'b0;
   localparam logic CSR_SAMPLE_COUNT = 1'b1;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_ACC  = 1'b1;

   localparam logic [SUM_BITS-1:0] COV_POS_LIMIT = SUM_BITS'((64'd1 << (COV_BITS - 1)) - 64'd1);
   localparam logic [SUM_BITS-1:0] COV_NEG_LIMIT = SUM_BITS'(64'd1 << (COV_BITS - 1));
   localparam logic [COV_BITS-1:0] COV_MAX       = {1'b0, {(COV_BITS - 1){1'b1}}};
   localparam logic [COV_BITS-1:0] COV_MIN       = {1'b1, {(COV_BITS - 1){1'b0}}};

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_DRAIN,
      ST_EMIT_RD,
      ST_EMIT_WAIT,
      ST_EMIT_DIV
   } back_state_type;

endpackage

// ----- rtl/scm_front.sv -----
// Front end: request intake, mean store and centering of each band value.
// Depends on scm_pkg; feeds scm_queue.
module scm_front #(
   parameter int MAX_BANDS   = 8,
   parameter int SAMPLE_BITS = 16,
   parameter int DATA_BITS   = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [DATA_BITS-1:0]                req_tdata,   // value_0 .. value_N-1
   input  logic                                req_tuser,   // mode
   input  scm_pkg::queue_stat_type             q_stat,
   output logic                                push,
   output logic [MAX_BANDS*(SAMPLE_BITS+1):0]  push_data
);
   import scm_pkg::*;

   localparam int CEN_BITS = SAMPLE_BITS + 1;

   logic signed [SAMPLE_BITS-1:0] mean_ff [MAX_BANDS];
   logic signed [SAMPLE_BITS-1:0] mean_in [MAX_BANDS];
   logic signed [SAMPLE_BITS-1:0] smp_w   [MAX_BANDS];
   logic signed [CEN_BITS-1:0]    cen_w   [MAX_BANDS];

   assign req_tready = !q_stat.full;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      push_data[MAX_BANDS*CEN_BITS] = req_tuser;
      for (int b = 0; b < MAX_BANDS; b++) begin
         smp_w[b] = $signed(req_tdata[b*SAMPLE_BITS +: SAMPLE_BITS]);
         cen_w[b] = CEN_BITS'(smp_w[b]) - CEN_BITS'(mean_ff[b]);
         push_data[b*CEN_BITS +: CEN_BITS] = cen_w[b];
         mean_in[b] = (push && req_tuser == MODE_LOAD) ? smp_w[b] : mean_ff[b];
      end
   end

   always_ff @(posedge clock) begin
      for (int b = 0; b < MAX_BANDS; b++) begin
         if (reset) begin
            mean_ff[b] <= '0;
         end else begin
            mean_ff[b] <= mean_in[b];
         end
      end
   end

endmodule

// ----- rtl/scm_queue.sv -----
// Short request queue between the front end and the back end.
// Depends on scm_pkg.
module scm_queue #(
   parameter int WIDTH = 137
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [WIDTH-1:0]        push_data,
   input  logic                    pop,
   output logic [WIDTH-1:0]        head_data,
   output scm_pkg::queue_stat_type stat
);
   import scm_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0]    entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign head_data  = entry_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/scm_div.sv -----
// Radix-2 restoring divider with truncation toward zero and saturation to
// the covariance range. Depends on scm_pkg; used by scm_back.
module scm_div #(
   parameter int DIV_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [scm_pkg::SUM_BITS-1:0] dividend,
   input  logic [DIV_BITS-1:0]          divisor,
   output logic                         busy,
   output logic [scm_pkg::COV_BITS-1:0] quot
);
   import scm_pkg::*;

   localparam int STEP_BITS = $clog2(SUM_BITS);

   logic                 busy_ff, busy_in;
   logic                 fix_ff, fix_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [SUM_BITS-1:0]  mag_ff, mag_in;
   logic [DIV_BITS-1:0]  rem_ff, rem_in;
   logic [DIV_BITS-1:0]  dvs_ff, dvs_in;
   logic                 neg_ff, neg_in;
   logic [COV_BITS-1:0]  quot_ff, quot_in;
   logic [DIV_BITS:0]    rem_sh_w, rem_sub_w;

   assign busy = busy_ff;
   assign quot = quot_ff;

   always_comb begin
      busy_in   = busy_ff;
      fix_in    = fix_ff;
      step_in   = step_ff;
      mag_in    = mag_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      neg_in    = neg_ff;
      quot_in   = quot_ff;
      rem_sh_w  = {rem_ff, mag_ff[SUM_BITS-1]};
      rem_sub_w = rem_sh_w - {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         fix_in  = 1'b0;
         step_in = '0;
         neg_in  = dividend[SUM_BITS-1];
         mag_in  = dividend[SUM_BITS-1] ? SUM_BITS'(0) - dividend : dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff && fix_ff) begin
         busy_in = 1'b0;
         fix_in  = 1'b0;
         if (!neg_ff) begin
            quot_in = (mag_ff > COV_POS_LIMIT) ? COV_MAX : mag_ff[COV_BITS-1:0];
         end else begin
            quot_in = (mag_ff > COV_NEG_LIMIT) ? COV_MIN
                                               : COV_BITS'(0) - mag_ff[COV_BITS-1:0];
         end
      end else if (busy_ff) begin
         if (rem_sh_w >= {1'b0, dvs_ff}) begin
            rem_in = rem_sub_w[DIV_BITS-1:0];
            mag_in = {mag_ff[SUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_sh_w[DIV_BITS-1:0];
            mag_in = {mag_ff[SUM_BITS-2:0], 1'b0};
         end
         step_in = step_ff + STEP_BITS'(1);
         if (step_ff == STEP_BITS'(SUM_BITS - 1)) begin
            fix_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         fix_ff  <= fix_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end

endmodule

// ----- rtl/scm_back.sv -----
// Back end: product accumulation into the sum memory, then the divide and
// result pass. Depends on scm_pkg and scm_div; fed by scm_queue.
module scm_back #(
   parameter int MAX_BANDS   = 8,
   parameter int MAX_SAMPLES = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  scm_pkg::queue_stat_type             q_stat,
   input  logic [MAX_BANDS*(SAMPLE_BITS+1):0]  head_data,
   output logic                                pop,
   input  logic [scm_pkg::BAND_CNT_BITS-1:0]   band_count,
   input  logic [scm_pkg::SAMPLE_CNT_BITS-1:0] sample_count,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [scm_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,   // row_band, column_band, covariance
   output logic                                rsp_tlast    // final_entry
);
   import scm_pkg::*;

   localparam int CEN_BITS  = SAMPLE_BITS + 1;
   localparam int PROD_BITS = 2 * CEN_BITS;
   localparam int DEPTH     = MAX_BANDS * MAX_BANDS;
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int BAND_BITS = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
   localparam int CNT_BITS  = $clog2(MAX_SAMPLES + 1);
   localparam int DIV_BITS  = $clog2(MAX_SAMPLES);

   back_state_type state_ff, state_in;

   logic [ADDR_BITS-1:0]       addr_ff, addr_in;
   logic [BAND_BITS-1:0]       row_ff, row_in;
   logic [BAND_BITS-1:0]       col_ff, col_in;
   logic [CNT_BITS-1:0]        seen_ff, seen_in;
   logic                       s1_vld_ff, s1_vld_in;
   logic [ADDR_BITS-1:0]       s1_addr_ff;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic [SUM_BITS-1:0]        sum_mem [DEPTH];
   logic [SUM_BITS-1:0]        rd_data_ff;
   logic                       rd_vld_ff;
   logic [DEPTH-1:0]           vld_ff;
   logic [ADDR_BITS-1:0]       rd_addr_w, emit_addr_w;
   logic [SUM_BITS-1:0]        wr_data_w;
   logic signed [CEN_BITS-1:0] cen_w [MAX_BANDS];
   logic                       head_mode_w;
   logic [BAND_BITS-1:0]       nb_last_w;
   logic [CNT_BITS-1:0]        ns_w;
   logic [DIV_BITS-1:0]        divisor_w;
   logic                       clear, load, last_w, out_free;
   logic                       div_start, div_busy;
   logic [COV_BITS-1:0]        div_quot;
   logic                       rsp_tvalid_ff, rsp_tvalid_in;
   logic [BAND_IDX_BITS-1:0]   rsp_row_ff, rsp_col_ff;
   logic [COV_BITS-1:0]        rsp_cov_ff;
   logic                       rsp_last_ff;

   always_comb begin
      head_mode_w = head_data[MAX_BANDS*CEN_BITS];
      for (int b = 0; b < MAX_BANDS; b++) begin
         cen_w[b] = $signed(head_data[b*CEN_BITS +: CEN_BITS]);
      end
   end

   always_comb begin
      if (band_count == '0) begin
         nb_last_w = '0;
      end else if (32'(band_count) > MAX_BANDS) begin
         nb_last_w = BAND_BITS'(MAX_BANDS - 1);
      end else begin
         nb_last_w = BAND_BITS'(band_count - BAND_CNT_BITS'(1));
      end
      if (sample_count < SAMPLE_CNT_BITS'(2)) begin
         ns_w = CNT_BITS'(2);
      end else if (32'(sample_count) > MAX_SAMPLES) begin
         ns_w = CNT_BITS'(MAX_SAMPLES);
      end else begin
         ns_w = CNT_BITS'(sample_count);
      end
      divisor_w = DIV_BITS'(ns_w - CNT_BITS'(1));
   end

   assign emit_addr_w = ADDR_BITS'(32'(row_ff) * MAX_BANDS + 32'(col_ff));
   assign last_w      = (row_ff == nb_last_w) && (col_ff == nb_last_w);
   assign out_free    = !rsp_tvalid_ff || rsp_tready;
   assign prod_in     = PROD_BITS'(cen_w[row_ff]) * PROD_BITS'(cen_w[col_ff]);
   assign wr_data_w   = (rd_vld_ff ? rd_data_ff : SUM_BITS'(0)) + SUM_BITS'(prod_ff);

   always_comb begin
      state_in  = state_ff;
      addr_in   = addr_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      seen_in   = seen_ff;
      s1_vld_in = 1'b0;
      pop       = 1'b0;
      clear     = 1'b0;
      load      = 1'b0;
      div_start = 1'b0;
      rd_addr_w = addr_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               if (head_mode_w == MODE_LOAD) begin
                  pop     = 1'b1;
                  clear   = 1'b1;
                  seen_in = '0;
               end else begin
                  state_in = ST_ACC;
                  addr_in  = '0;
                  row_in   = '0;
                  col_in   = '0;
               end
            end
         end
         ST_ACC: begin
            s1_vld_in = 1'b1;
            addr_in   = addr_ff + ADDR_BITS'(1);
            if (col_ff == BAND_BITS'(MAX_BANDS - 1)) begin
               col_in = '0;
               row_in = row_ff + BAND_BITS'(1);
            end else begin
               col_in = col_ff + BAND_BITS'(1);
            end
            if (addr_ff == ADDR_BITS'(DEPTH - 1)) begin
               pop      = 1'b1;
               seen_in  = seen_ff + CNT_BITS'(1);
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            row_in   = '0;
            col_in   = '0;
            state_in = (seen_ff >= ns_w) ? ST_EMIT_RD : ST_IDLE;
         end
         ST_EMIT_RD: begin
            rd_addr_w = emit_addr_w;
            state_in  = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            div_start = 1'b1;
            state_in  = ST_EMIT_DIV;
         end
         ST_EMIT_DIV: begin
            if (!div_busy && out_free) begin
               load = 1'b1;
               if (col_ff == nb_last_w) begin
                  col_in = '0;
                  row_in = row_ff + BAND_BITS'(1);
               end else begin
                  col_in = col_ff + BAND_BITS'(1);
               end
               if (last_w) begin
                  clear    = 1'b1;
                  seen_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         addr_ff       <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         seen_ff       <= '0;
         s1_vld_ff     <= 1'b0;
         vld_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         seen_ff       <= seen_in;
         s1_vld_ff     <= s1_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (clear) begin
            vld_ff <= '0;
         end else if (s1_vld_ff) begin
            vld_ff[s1_addr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff <= addr_ff;
      prod_ff    <= prod_in;
      rd_data_ff <= sum_mem[rd_addr_w];
      rd_vld_ff  <= vld_ff[rd_addr_w];
      if (s1_vld_ff) begin
         sum_mem[s1_addr_ff] <= wr_data_w;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_row_ff  <= BAND_IDX_BITS'(row_ff);
         rsp_col_ff  <= BAND_IDX_BITS'(col_ff);
         rsp_cov_ff  <= div_quot;
         rsp_last_ff <= last_w;
      end
   end

   scm_div #(
      .DIV_BITS (DIV_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rd_vld_ff ? rd_data_ff : SUM_BITS'(0)),
      .divisor  (divisor_w),
      .busy     (div_busy),
      .quot     (div_quot)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {rsp_cov_ff, rsp_col_ff, rsp_row_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- rtl/sample_covariance_matrix.sv -----
// Sample covariance matrix top level: configuration registers and the
// front end, request queue and back end. Depends on scm_pkg and all scm_ modules.
//
//   channel  dir  handshake               payload
//   req_     in   req_tvalid/req_tready   tdata value_0..value_7, tuser mode
//   rsp_     out  rsp_tvalid/rsp_tready   tdata row/column/covariance, tlast final_entry
//   csr_     in   psel/penable/pready     band_count @0x0, sample_count @0x4
//
// A sample request makes one read-modify-write of the sum memory per matrix
// entry in the back end, then a drain step. A mean-load request is popped from
// the idle state. Each emitted entry passes the one-bit-per-cycle divider.
// Reset clears the entry valid bits at once; no clearing pass is needed.
// The request queue holds four requests, so intake goes on while the back end
// or the result register stalls.
module sample_covariance_matrix #(
   parameter int MAX_BANDS   = 8,
   parameter int MAX_SAMPLES = 4096,
   parameter int SAMPLE_BITS = 16,
   localparam int REQ_DATA_BITS = ((MAX_BANDS * SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [REQ_DATA_BITS-1:0]            req_tdata,   // value_0 .. value_7
   input  logic                                req_tuser,   // mode
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [scm_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,   // row_band, column_band, covariance
   output logic                                rsp_tlast,   // final_entry
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [scm_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [scm_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [scm_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);
   import scm_pkg::*;

   localparam int ENTRY_BITS = MAX_BANDS * (SAMPLE_BITS + 1) + 1;

   logic [BAND_CNT_BITS-1:0]   band_count_ff, band_count_in;
   logic [SAMPLE_CNT_BITS-1:0] sample_count_ff, sample_count_in;
   logic                       csr_wr;
   logic                       csr_idx;
   logic                       push, pop;
   logic [ENTRY_BITS-1:0]      push_data, head_data;
   queue_stat_type             q_stat;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[CSR_IDX_BIT];

   always_comb begin
      band_count_in   = band_count_ff;
      sample_count_in = sample_count_ff;
      if (csr_wr) begin
         case (csr_idx)
            CSR_BAND_COUNT: begin
               band_count_in = csr_pwdata[BAND_CNT_BITS-1:0];
            end
            CSR_SAMPLE_COUNT: begin
               sample_count_in = csr_pwdata[SAMPLE_CNT_BITS-1:0];
            end
            default: begin
               band_count_in = band_count_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_BAND_COUNT: begin
            csr_prdata = CSR_DATA_BITS'(band_count_ff);
         end
         CSR_SAMPLE_COUNT: begin
            csr_prdata = CSR_DATA_BITS'(sample_count_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         band_count_ff   <= BAND_COUNT_RESET;
         sample_count_ff <= SAMPLE_COUNT_RESET;
      end else begin
         band_count_ff   <= band_count_in;
         sample_count_ff <= sample_count_in;
      end
   end

   scm_front #(
      .MAX_BANDS   (MAX_BANDS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .DATA_BITS   (REQ_DATA_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_stat     (q_stat),
      .push       (push),
      .push_data  (push_data)
   );

   scm_queue #(
      .WIDTH (ENTRY_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .stat      (q_stat)
   );

   scm_back #(
      .MAX_BANDS   (MAX_BANDS),
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_stat       (q_stat),
      .head_data    (head_data),
      .pop          (pop),
      .band_count   (band_count_ff),
      .sample_count (sample_count_ff),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

endmodule
